[hdl/wmbl_pkg.sv]
// wmbl_pkg: shared types, constants and helpers for the warp mesh bilinear lookup.
// Used by wmbl_mesh_ram and warp_mesh_bilinear_lookup; depends on nothing.

package wmbl_pkg;

   // grid defaults (cells per axis; nodes per axis is one more)
   localparam int GRID_COLS_DEF = 64;
   localparam int GRID_ROWS_DEF = 64;

   // request / response field widths
   localparam int IDX_W   = 7;
   localparam int COORD_W = 16;
   localparam int HALF_W  = 15;
   localparam int SCALE_W = 16;
   localparam int NODE_W  = 32;   // v in [31:16], u in [15:0]

   // csr port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [HALF_W-1:0]  HALF_EXTENT_RST = 15'd4096;
   localparam logic [SCALE_W-1:0] COL_SCALE_RST   = 16'd8192;
   localparam logic [SCALE_W-1:0] ROW_SCALE_RST   = 16'd8192;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_EXTENT = 2'd0,
      CSR_COL_SCALE   = 2'd1,
      CSR_ROW_SCALE   = 2'd2
   } csr_idx_type;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // arithmetic widths
   localparam int SUM_W  = 17;            // point + half extent, signed Q4.12
   localparam int MAP_W  = 34;            // sum * scale, signed Q.20
   localparam int CELL_W = 12;            // integer part of the mapped coordinate
   localparam int FRAC_W = 12;            // Q0.12 fraction
   localparam int WX_W   = FRAC_W + 1;    // 4096 - f needs 13 bits
   localparam int WGT_W  = 25;            // corner weight, Q0.24, max 2^24
   localparam int PROD_W = 42;            // node * weight and the four-term sum
   localparam int RES_W  = PROD_W - 24;   // sum after dropping 24 fraction bits

   localparam logic [WX_W-1:0] ONE_Q12 = 13'd4096;
   localparam logic signed [PROD_W-1:0] RND_HALF = 42'sd8388608;   // 2^23

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_CELL,
      ST_FETCH,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_map;
      logic load_cell;
      logic fetch;
      logic finish;
   } ctl_type;

   // round half up from Q.24 and clamp to signed 16 bits
   function automatic logic [COORD_W-1:0] round_sat(input logic signed [PROD_W-1:0] acc);
      logic signed [PROD_W-1:0] biased;
      logic signed [RES_W-1:0]  r;
      biased = acc + RND_HALF;
      r = signed'(biased[PROD_W-1:24]);
      if (r > 18'sd32767) begin
         return 16'h7FFF;
      end else if (r < -18'sd32768) begin
         return 16'h8000;
      end
      return r[COORD_W-1:0];
   endfunction

endpackage

[hdl/wmbl_mesh_ram.sv]
// wmbl_mesh_ram: single-port mesh node store, one access per cycle, registered read.
// Depends on wmbl_pkg for the word width.

module wmbl_mesh_ram #(
   parameter int DEPTH  = (wmbl_pkg::GRID_COLS_DEF + 1) * (wmbl_pkg::GRID_ROWS_DEF + 1),
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [ADDR_W-1:0]           addr,
   input  logic [wmbl_pkg::NODE_W-1:0] wdata,
   output logic [wmbl_pkg::NODE_W-1:0] rdata
);

   logic [wmbl_pkg::NODE_W-1:0] mem [DEPTH];
   logic [wmbl_pkg::NODE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/warp_mesh_bilinear_lookup.sv]
// warp_mesh_bilinear_lookup: top level, csr registers, control sequencer and datapath.
// Depends on wmbl_pkg and instantiates wmbl_mesh_ram.

// A load request (mode 0) writes one mesh node (u, v) into a single-port store of
// (GRID_COLS+1)*(GRID_ROWS+1) words as it is taken; back-to-back loads run at one per
// cycle while the block is idle and produce no response. Nodes with col > GRID_COLS
// or row > GRID_ROWS are dropped. A query request (mode 1) produces exactly one
// response and occupies the block from acceptance to the next acceptance: ST_MAP for
// the coordinate-times-scale multiply, ST_CELL for the cell decode, four reads of the store
// in ST_FETCH (one corner per cycle through its single port), ST_DRAIN to drain the weight
// multiply and accumulate, ST_DONE to load the response register, and ST_IDLE, which
// takes the next request. A query whose cell falls outside the grid skips the reads
// and the drain and finishes with in_range 0 and zero outputs. The response sits in an
// output register, so a new request is taken while the previous response still waits
// for rsp_ready; a query only stalls in its last step if that register is still full.
// The store has no reset: every node a query can touch must be loaded first. CSR writes
// are meant for idle periods only.

module warp_mesh_bilinear_lookup #(
   parameter int GRID_COLS = wmbl_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS = wmbl_pkg::GRID_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   // csr write port
   input  logic                                csr_we,
   input  logic [wmbl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wmbl_pkg::CSR_DATA_W-1:0]     csr_wdata,

   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [wmbl_pkg::IDX_W-1:0]          req_node_col,
   input  logic [wmbl_pkg::IDX_W-1:0]          req_node_row,
   input  logic signed [wmbl_pkg::COORD_W-1:0] req_node_u,
   input  logic signed [wmbl_pkg::COORD_W-1:0] req_node_v,
   input  logic signed [wmbl_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [wmbl_pkg::COORD_W-1:0] req_point_y,

   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [wmbl_pkg::COORD_W-1:0] rsp_out_u,
   output logic signed [wmbl_pkg::COORD_W-1:0] rsp_out_v,
   output logic                                rsp_in_range
);

   localparam int STRIDE     = GRID_COLS + 1;
   localparam int NODE_COUNT = (GRID_COLS + 1) * (GRID_ROWS + 1);
   localparam int ADDR_W     = $clog2(NODE_COUNT);

   localparam int CW = wmbl_pkg::COORD_W;
   localparam int PW = wmbl_pkg::PROD_W;

   // ---------------------------------------------------------------- csr
   logic [wmbl_pkg::HALF_W-1:0]  half_ff;
   logic [wmbl_pkg::SCALE_W-1:0] col_scale_ff;
   logic [wmbl_pkg::SCALE_W-1:0] row_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff      <= wmbl_pkg::HALF_EXTENT_RST;
         col_scale_ff <= wmbl_pkg::COL_SCALE_RST;
         row_scale_ff <= wmbl_pkg::ROW_SCALE_RST;
      end else if (csr_we) begin
         case (wmbl_pkg::csr_idx_type'(csr_index))
            wmbl_pkg::CSR_HALF_EXTENT: half_ff      <= csr_wdata[wmbl_pkg::HALF_W-1:0];
            wmbl_pkg::CSR_COL_SCALE:   col_scale_ff <= csr_wdata;
            wmbl_pkg::CSR_ROW_SCALE:   row_scale_ff <= csr_wdata;
            default: ;   // unmapped index, dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- control
   wmbl_pkg::state_type state_ff, state_in;
   wmbl_pkg::ctl_type   ctl;

   logic [1:0] corner_ff, corner_in;
   logic       rd_vld_ff, prd_vld_ff;
   logic       hit_ff, hit_in;        // query cell lies inside the grid
   logic       out_free;

   assign out_free  = !rsp_valid || rsp_ready;
   assign req_ready = (state_ff == wmbl_pkg::ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wmbl_pkg::ST_IDLE: begin
            if (req_valid && req_mode == wmbl_pkg::MODE_QUERY) begin
               state_in = wmbl_pkg::ST_MAP;
            end
         end
         wmbl_pkg::ST_MAP:   state_in = wmbl_pkg::ST_CELL;
         wmbl_pkg::ST_CELL:  state_in = hit_in ? wmbl_pkg::ST_FETCH : wmbl_pkg::ST_DONE;
         wmbl_pkg::ST_FETCH: begin
            if (corner_ff == 2'd3) begin
               state_in = wmbl_pkg::ST_DRAIN;
            end
         end
         wmbl_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !prd_vld_ff) begin
               state_in = wmbl_pkg::ST_DONE;
            end
         end
         wmbl_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = wmbl_pkg::ST_IDLE;
            end
         end
         default: state_in = wmbl_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      ctl = '0;
      case (state_ff)
         wmbl_pkg::ST_MAP:   ctl.load_map  = 1'b1;
         wmbl_pkg::ST_CELL:  ctl.load_cell = 1'b1;
         wmbl_pkg::ST_FETCH: ctl.fetch     = 1'b1;
         wmbl_pkg::ST_DONE:  ctl.finish    = out_free;
         default: ;
      endcase
   end

   assign corner_in = ctl.fetch ? corner_ff + 2'd1 : (ctl.load_cell ? 2'd0 : corner_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= wmbl_pkg::ST_IDLE;
         corner_ff  <= 2'd0;
         rd_vld_ff  <= 1'b0;
         prd_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         corner_ff  <= corner_in;
         rd_vld_ff  <= ctl.fetch;
         prd_vld_ff <= rd_vld_ff;
      end
   end

   // ---------------------------------------------------------------- capture and map
   logic signed [CW-1:0] pt_x_ff, pt_y_ff;
   logic accept_query;

   assign accept_query = req_valid && req_ready && req_mode == wmbl_pkg::MODE_QUERY;

   always_ff @(posedge clock) begin
      if (accept_query) begin
         pt_x_ff <= req_point_x;
         pt_y_ff <= req_point_y;
      end
   end

   // s = point + half extent (Q4.12), P = s * scale (Q.20)
   logic signed [wmbl_pkg::SUM_W-1:0] sum_x, sum_y;
   logic signed [wmbl_pkg::MAP_W-1:0] map_x_ff, map_x_in, map_y_ff, map_y_in;

   assign sum_x = $signed({pt_x_ff[CW-1], pt_x_ff}) + $signed({2'b00, half_ff});
   assign sum_y = $signed({pt_y_ff[CW-1], pt_y_ff}) + $signed({2'b00, half_ff});

   assign map_x_in = sum_x * $signed({1'b0, col_scale_ff});
   assign map_y_in = sum_y * $signed({1'b0, row_scale_ff});

   always_ff @(posedge clock) begin
      if (ctl.load_map) begin
         map_x_ff <= map_x_in;
         map_y_ff <= map_y_in;
      end
   end

   // ---------------------------------------------------------------- cell decode
   logic [wmbl_pkg::CELL_W-1:0] cell_x, cell_y;
   logic [wmbl_pkg::FRAC_W-1:0] fx_ff, fy_ff;
   logic [ADDR_W-1:0]           base_ff, base_in;

   assign cell_x = map_x_ff[20 +: wmbl_pkg::CELL_W];
   assign cell_y = map_y_ff[20 +: wmbl_pkg::CELL_W];

   // negative mapping or cell index + 1 past the last node misses the grid
   assign hit_in = !map_x_ff[wmbl_pkg::MAP_W-1] && !map_y_ff[wmbl_pkg::MAP_W-1] &&
                   (cell_x < wmbl_pkg::CELL_W'(GRID_COLS)) &&
                   (cell_y < wmbl_pkg::CELL_W'(GRID_ROWS));

   assign base_in = ADDR_W'(int'(cell_y) * STRIDE + int'(cell_x));

   always_ff @(posedge clock) begin
      if (ctl.load_cell) begin
         fx_ff   <= map_x_ff[8 +: wmbl_pkg::FRAC_W];
         fy_ff   <= map_y_ff[8 +: wmbl_pkg::FRAC_W];
         base_ff <= base_in;
         hit_ff  <= hit_in;
      end
   end

   // ---------------------------------------------------------------- corner fetch
   // corner bit 0 steps x, bit 1 steps y
   logic [wmbl_pkg::WX_W-1:0]  wx, wy;
   logic [wmbl_pkg::WGT_W-1:0] wx_e, wy_e, wgt_ff, wgt_in;
   logic [ADDR_W-1:0]          rd_addr;

   assign wx = corner_ff[0] ? {1'b0, fx_ff} : wmbl_pkg::ONE_Q12 - {1'b0, fx_ff};
   assign wy = corner_ff[1] ? {1'b0, fy_ff} : wmbl_pkg::ONE_Q12 - {1'b0, fy_ff};
   assign wx_e = wmbl_pkg::WGT_W'(wx);
   assign wy_e = wmbl_pkg::WGT_W'(wy);
   assign wgt_in = wx_e * wy_e;

   assign rd_addr = base_ff + (corner_ff[0] ? ADDR_W'(1) : ADDR_W'(0))
                            + (corner_ff[1] ? ADDR_W'(STRIDE) : ADDR_W'(0));

   always_ff @(posedge clock) begin
      if (ctl.fetch) begin
         wgt_ff <= wgt_in;   // lines up with the registered read data
      end
   end

   // ---------------------------------------------------------------- node store
   logic                        load_ok;
   logic                        mem_we;
   logic [ADDR_W-1:0]           wr_addr, mem_addr;
   logic [wmbl_pkg::NODE_W-1:0] mem_rdata;

   assign load_ok = (int'(req_node_col) <= GRID_COLS) && (int'(req_node_row) <= GRID_ROWS);
   assign mem_we  = req_valid && req_ready && req_mode == wmbl_pkg::MODE_LOAD && load_ok;
   assign wr_addr = ADDR_W'(int'(req_node_row) * STRIDE + int'(req_node_col));
   // loads happen only in idle, reads only during fetch: no port conflict
   assign mem_addr = mem_we ? wr_addr : rd_addr;

   wmbl_mesh_ram #(
      .DEPTH  (NODE_COUNT),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata ({req_node_v, req_node_u}),
      .rdata (mem_rdata)
   );

   // ---------------------------------------------------------------- weight and sum
   logic signed [PW-1:0] prd_u_ff, prd_u_in, prd_v_ff, prd_v_in;
   logic signed [PW-1:0] acc_u_ff, acc_u_in, acc_v_ff, acc_v_in;

   assign prd_u_in = $signed(mem_rdata[CW-1:0])      * $signed({1'b0, wgt_ff});
   assign prd_v_in = $signed(mem_rdata[2*CW-1:CW])   * $signed({1'b0, wgt_ff});

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prd_u_ff <= prd_u_in;
         prd_v_ff <= prd_v_in;
      end
   end

   always_comb begin
      acc_u_in = acc_u_ff;
      acc_v_in = acc_v_ff;
      if (ctl.load_cell) begin
         acc_u_in = '0;
         acc_v_in = '0;
      end else if (prd_vld_ff) begin
         acc_u_in = acc_u_ff + prd_u_ff;
         acc_v_in = acc_v_ff + prd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_u_ff <= acc_u_in;
      acc_v_ff <= acc_v_in;
   end

   // ---------------------------------------------------------------- response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0] out_u_ff, out_v_ff;
   logic                 in_range_ff;

   assign rsp_valid_in = ctl.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         in_range_ff <= hit_ff;
         out_u_ff    <= hit_ff ? $signed(wmbl_pkg::round_sat(acc_u_ff)) : '0;
         out_v_ff    <= hit_ff ? $signed(wmbl_pkg::round_sat(acc_v_ff)) : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_u    = out_u_ff;
   assign rsp_out_v    = out_v_ff;
   assign rsp_in_range = in_range_ff;

endmodule
